@@ hdl/rc4_layered_stream_decryptor_core_macros.svh @@
// Assertion macros used by the checker file of the decryptor.
`ifndef RC4_LAYERED_STREAM_DECRYPTOR_CORE_MACROS_SVH
`define RC4_LAYERED_STREAM_DECRYPTOR_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is applied.
`define RC4_LSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("decryptor check failed (same cycle)");

// Next-cycle implication, switched off while reset is applied.
`define RC4_LSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("decryptor check failed (next cycle)");

`endif

@@ hdl/rc4_lsd_pkg.sv @@
package rc4_lsd_pkg;

  // Key geometry: the key words are fixed by the register map.
  localparam int KEY_BYTES = 48;
  localparam int KEY_WORDS = 6;
  localparam int KEY_WORD_W = 64;
  localparam int KEY_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Byte and permutation geometry.
  localparam int BYTE_W = 8;
  localparam int PERM_DEPTH = 256;

  // Fixed whitening byte applied to every data byte.
  localparam logic [BYTE_W-1:0] WHITEN_BYTE = 8'h9A;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_MASK = 3'd7;

  // Queue between the front end and the engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified data byte waiting for the engine.
  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic              end_of_message;
    logic              start_of_message;
  } item_t;

  // Engine sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCH_A,
    ST_SCH_B,
    ST_SCH_C,
    ST_SCH_D,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_KS_D
  } engine_state_e;

endpackage

@@ hdl/rc4_layered_stream_decryptor_core.sv @@
// Layered RC4 byte stream decryptor.
// Input channel: in_valid_i/in_ready_o carry cipher_byte_i and
// end_of_message_i; output channel: out_valid_o/out_ready_i carry
// plain_byte_o and final_flag_o, one result per input byte, in order.
// Key words, key mask and static mask are written through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is idle.
// The front end tags each byte with whether it opens a message and puts
// it into a two-entry queue, so input is taken while the engine works.
// The engine owns a 256 x 8 permutation memory with one write port and
// one registered read port; that port sets the timing.
// First byte of a message: the table is filled, the key schedule swaps
// every entry, then the keystream step runs.
// Every further byte: a queue pop, then the keystream step.
// Reset clears the queue, the engine state, the output valid flag and all
// configuration registers; the first byte after reset schedules the key.
// When the receiver stalls the result is held in the output register;
// the engine then waits, and the queue fills and drops in_ready_o.
module rc4_layered_stream_decryptor_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rc4_lsd_pkg::BYTE_W-1:0]     cipher_byte_i,
  input  logic                               end_of_message_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rc4_lsd_pkg::BYTE_W-1:0]     plain_byte_o,
  output logic                               final_flag_o,
  input  logic                               cfg_we_i,
  input  logic [rc4_lsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4_lsd_pkg::KEY_WORD_W-1:0] cfg_data_i
);
  import rc4_lsd_pkg::*;

  logic  push, queue_full, queue_valid, queue_pop;
  item_t push_item, head_item;

  // Front end: accepts and classifies bytes.
  rc4_lsd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cipher_byte_i    (cipher_byte_i),
    .end_of_message_i (end_of_message_i),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .item_o           (push_item)
  );

  // Queue between front end and engine.
  rc4_lsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (head_item)
  );

  // Engine: key schedule, keystream and output register.
  rc4_lsd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (queue_valid),
    .q_item_i     (head_item),
    .q_pop_o      (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .plain_byte_o (plain_byte_o),
    .final_flag_o (final_flag_o)
  );

endmodule

@@ hdl/rc4_lsd_front.sv @@
module rc4_lsd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rc4_lsd_pkg::BYTE_W-1:0] cipher_byte_i,
  input  logic                          end_of_message_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output rc4_lsd_pkg::item_t            item_o
);
  import rc4_lsd_pkg::*;

  logic start_q, start_d;

  // Input is taken whenever the queue has room.
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Tag each byte with whether it opens a message.
  always_comb begin
    item_o.cipher_byte      = cipher_byte_i;
    item_o.end_of_message   = end_of_message_i;
    item_o.start_of_message = start_q;
    start_d = start_q;
    if (push_o) begin
      start_d = end_of_message_i;
    end
  end

  // The byte after a final byte starts a new message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else begin
      start_q <= start_d;
    end
  end

endmodule

@@ hdl/rc4_lsd_queue.sv @@
module rc4_lsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rc4_lsd_pkg::item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rc4_lsd_pkg::item_t item_o
);
  import rc4_lsd_pkg::*;

  item_t                  slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/rc4_lsd_engine.sv @@
module rc4_lsd_engine (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rc4_lsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rc4_lsd_pkg::KEY_WORD_W-1:0]    cfg_data_i,
  input  logic                                  q_valid_i,
  input  rc4_lsd_pkg::item_t                    q_item_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rc4_lsd_pkg::BYTE_W-1:0]        plain_byte_o,
  output logic                                  final_flag_o
);
  import rc4_lsd_pkg::*;

  // Configuration registers.
  logic [KEY_WORD_W-1:0] key_word_q [KEY_WORDS];
  logic [BYTE_W-1:0]     key_mask_q;
  logic [BYTE_W-1:0]     static_mask_q;
  logic [BYTE_W-1:0]     key_bytes [KEY_BYTES];

  // Sequencer and working registers.
  engine_state_e         state_q, state_d;
  logic [BYTE_W-1:0]     n_q, n_d;
  logic [KEY_IDX_W-1:0]  kidx_q, kidx_d;
  logic [BYTE_W-1:0]     i_q, i_d;
  logic [BYTE_W-1:0]     j_q, j_d;
  logic [BYTE_W-1:0]     si_q, si_d;
  logic [BYTE_W-1:0]     sj_q, sj_d;
  logic [BYTE_W-1:0]     t_q, t_d;
  logic [BYTE_W-1:0]     byte_q, byte_d;
  logic                  eom_q, eom_d;
  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     plain_q, plain_d;
  logic                  final_q, final_d;

  // Permutation memory: one write and one registered read per cycle.
  logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
  logic [BYTE_W-1:0]     rdata_q;
  logic                  mem_we;
  logic [BYTE_W-1:0]     mem_waddr, mem_wdata, mem_raddr;

  // Configuration writes; indexes 0 to 5 select the key words, 6 the key mask, 7 the static mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word_q[w] <= '0;
      end
      key_mask_q    <= '0;
      static_mask_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i < REG_KEY_MASK) begin
        key_word_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == REG_KEY_MASK) begin
        key_mask_q <= cfg_data_i[BYTE_W-1:0];
      end else if (cfg_index_i == REG_STATIC_MASK) begin
        static_mask_q <= cfg_data_i[BYTE_W-1:0];
      end
    end
  end

  // Masked key bytes, byte 0 in the low bits of word 0.
  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_bytes[b] = key_word_q[b / 8][(b % 8) * 8 +: 8] ^ key_mask_q;
    end
  end

  // Sequencer: fill, key schedule swaps, then one keystream step per byte.
  always_comb begin
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] ks;
    state_d     = state_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    byte_d      = byte_q;
    eom_d       = eom_q;
    plain_d     = plain_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = n_q;
    mem_wdata   = n_q;
    mem_raddr   = n_q;
    sum         = '0;
    ks          = rdata_q;

    // A waiting result leaves on a transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          byte_d  = q_item_i.cipher_byte;
          eom_d   = q_item_i.end_of_message;
          if (q_item_i.start_of_message) begin
            n_d     = '0;
            state_d = ST_FILL;
          end else begin
            state_d = ST_KS_A;
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = n_q;
        n_d       = n_q + 1'b1;
        if (n_q == BYTE_W'(PERM_DEPTH - 1)) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = ST_SCH_A;
        end
      end
      ST_SCH_A: begin
        mem_raddr = n_q;
        state_d   = ST_SCH_B;
      end
      ST_SCH_B: begin
        sum       = j_q + rdata_q + key_bytes[kidx_q];
        si_d      = rdata_q;
        j_d       = sum;
        mem_raddr = sum;
        state_d   = ST_SCH_C;
      end
      ST_SCH_C: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = rdata_q;
        state_d   = ST_SCH_D;
      end
      ST_SCH_D: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        n_d       = n_q + 1'b1;
        kidx_d    = (kidx_q == KEY_IDX_W'(KEY_BYTES - 1)) ? '0 : kidx_q + 1'b1;
        if (n_q == BYTE_W'(PERM_DEPTH - 1)) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_KS_A;
        end else begin
          state_d = ST_SCH_A;
        end
      end
      ST_KS_A: begin
        sum       = i_q + 1'b1;
        i_d       = sum;
        mem_raddr = sum;
        state_d   = ST_KS_B;
      end
      ST_KS_B: begin
        sum       = j_q + rdata_q;
        si_d      = rdata_q;
        j_d       = sum;
        mem_raddr = sum;
        state_d   = ST_KS_C;
      end
      ST_KS_C: begin
        sum       = si_q + rdata_q;
        sj_d      = rdata_q;
        t_d       = sum;
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
        mem_raddr = sum;
        state_d   = ST_KS_D;
      end
      ST_KS_D: begin
        // The read of the output entry may predate the swap, so the two
        // swapped entries are forwarded from the working registers.
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        mem_raddr = t_q;
        if (t_q == i_q) begin
          ks = sj_q;
        end else if (t_q == j_q) begin
          ks = si_q;
        end else begin
          ks = rdata_q;
        end
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          plain_d     = byte_q ^ WHITEN_BYTE ^ static_mask_q ^ ks;
          final_d     = eom_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    si_q    <= si_d;
    sj_q    <= sj_d;
    t_q     <= t_d;
    byte_q  <= byte_d;
    eom_q   <= eom_d;
    plain_q <= plain_d;
    final_q <= final_d;
  end

  // Permutation memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= perm_mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = plain_q;
  assign final_flag_o = final_q;

endmodule

@@ hdl/rc4_lsd_checker.sv @@
`include "rc4_layered_stream_decryptor_core_macros.svh"

module rc4_lsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  plain_byte_o,
  input logic        final_flag_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] pending_q, pending_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Bytes taken in whose results have not yet been transferred out.
  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled result stays put until it is transferred.
  `RC4_LSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                       out_valid_o && $stable(plain_byte_o) && $stable(final_flag_o))

  // No result appears without a byte that caused it.
  `RC4_LSD_ASSERT_IMPL(a_no_invented, clk_i, rst_ni, out_valid_o, pending_q != 3'd0)

  // Queue, engine and output register hold at most four bytes.
  `RC4_LSD_ASSERT_IMPL(a_bounded, clk_i, rst_ni, in_xfer, pending_q < 3'd4 || out_xfer)

endmodule

bind rc4_layered_stream_decryptor_core rc4_lsd_checker u_rc4_lsd_checker (.*);

@@ tb/sv/rc4_layered_stream_decryptor_core_tb.sv @@
`timescale 1ns / 100ps

module rc4_layered_stream_decryptor_core_tb;
  import rc4_lsd_pkg::*;

  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 320;
  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = '0;

  typedef enum int {
    KEY_ZERO,
    KEY_ONES,
    KEY_RAMP,
    KEY_RANDOM
  } key_fill_e;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic              end_of_message;
  } cipher_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] plain_byte;
    logic              final_flag;
  } plain_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [BYTE_W-1:0]     cipher_byte_i = '0;
  logic                  end_of_message_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [BYTE_W-1:0]     plain_byte_o;
  logic                  final_flag_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [KEY_WORD_W-1:0] cfg_data_i = '0;

  // Bytes waiting to be sent and decrypted bytes still owed by the block.
  cipher_item_t cipher_queue[$];
  plain_item_t  plain_queue[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int schedules = 0;
  int reg_writes = 0;

  // Local copy of the configuration registers.
  logic [KEY_WORD_W-1:0] key_words [KEY_WORDS];
  logic [BYTE_W-1:0]     key_mask;
  logic [BYTE_W-1:0]     static_mask;

  // Local copy of the cipher state.
  logic [BYTE_W-1:0] perm [PERM_DEPTH];
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic              keyed;

  rc4_layered_stream_decryptor_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog_proc
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, plain_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Key schedule: identity fill, then one swap per entry driven by the masked key.
  function automatic void schedule_key();
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] kb;
    int k;
    j = '0;
    for (int n = 0; n < PERM_DEPTH; n++) perm[n] = n[BYTE_W-1:0];
    for (int n = 0; n < PERM_DEPTH; n++) begin
      k = n % KEY_BYTES;
      kb = key_words[k / 8][8 * (k % 8) +: 8] ^ key_mask;
      j = j + perm[n] + kb;
      t = perm[n];
      perm[n] = perm[j];
      perm[j] = t;
    end
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b1;
    schedules++;
  endfunction

  // One step of the keystream generator.
  function automatic logic [BYTE_W-1:0] keystream_byte();
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] sum;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    sum = perm[idx_i] + perm[idx_j];
    return perm[sum];
  endfunction

  // Decrypts one accepted byte; the first byte of a message schedules the key.
  function automatic plain_item_t decrypt_byte(input cipher_item_t c);
    plain_item_t p;
    if (!keyed) schedule_key();
    p.plain_byte = c.cipher_byte ^ WHITEN_BYTE ^ static_mask ^ keystream_byte();
    p.final_flag = c.end_of_message;
    if (c.end_of_message) keyed = 1'b0;
    return p;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Sender: a new byte is offered only once the previous transfer has happened.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    cipher_item_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (cipher_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = cipher_queue.pop_front();
        in_valid_i <= 1'b1;
        cipher_byte_i <= item.cipher_byte;
        end_of_message_i <= item.end_of_message;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready drops at random according to the current stall rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: results are checked before the input transfer of the same edge is predicted.
  always @(posedge clk_i) begin : check_proc
    plain_item_t want;
    plain_item_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.plain_byte = plain_byte_o;
        got.final_flag = final_flag_o;
        bytes_checked++;
        if (plain_queue.size() == 0) begin
          note_failure($sformatf("unexpected result plain_byte=%02h final_flag=%b",
                                 got.plain_byte, got.final_flag));
        end else begin
          want = plain_queue.pop_front();
          if (got.plain_byte !== want.plain_byte || got.final_flag !== want.final_flag) begin
            note_failure($sformatf({"mismatch: plain_byte exp %02h got %02h, ",
                                    "final_flag exp %b got %b"},
                                   want.plain_byte, got.plain_byte,
                                   want.final_flag, got.final_flag));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        bytes_sent++;
        plain_queue.insert(plain_queue.size(),
                           decrypt_byte({cipher_byte_i, end_of_message_i}));
      end
    end
  end

  // Register write; the local copy follows at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEY_MASK) key_mask = data[BYTE_W-1:0];
    else if (idx == REG_STATIC_MASK) static_mask = data[BYTE_W-1:0];
    else key_words[idx - REG_KEY_WORD_0] = data;
    reg_writes++;
  endtask

  task automatic load_key(input key_fill_e fill, input logic [BYTE_W-1:0] km,
                          input logic [BYTE_W-1:0] sm);
    logic [KEY_WORD_W-1:0] w;
    for (int n = 0; n < KEY_WORDS; n++) begin
      case (fill)
        KEY_ZERO: w = '0;
        KEY_ONES: w = '1;
        KEY_RAMP: begin
          // Each key byte holds its own index, which exposes any byte-order slip.
          for (int b = 0; b < 8; b++) w[8 * b +: 8] = BYTE_W'(8 * n + b);
        end
        default: w = {$urandom, $urandom};
      endcase
      write_reg(REG_KEY_WORD_0 + CFG_IDX_W'(n), w);
    end
    write_reg(REG_KEY_MASK, KEY_WORD_W'(km));
    write_reg(REG_STATIC_MASK, KEY_WORD_W'(sm));
    @(negedge clk_i);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] c, input logic eom);
    cipher_queue.insert(cipher_queue.size(), {c, eom});
  endtask

  // Random bytes; only the last may close the message.
  task automatic queue_message(input int len, input logic close);
    for (int n = 0; n < len; n++) begin
      queue_byte(BYTE_W'($urandom_range(255)), close && (n == len - 1));
    end
  endtask

  // Mostly short and medium messages, since every message pays for a key schedule.
  function automatic int message_length();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 1;
    else if (r < 90) return $urandom_range(30, 2);
    else return $urandom_range(120, 31);
  endfunction

  // Returns once every queued byte has been transferred and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cipher_queue.size() != 0 || in_valid_i || plain_queue.size() != 0);
  endtask

  initial begin : stimulus_proc
    int remaining;
    int len;
    for (int w = 0; w < KEY_WORDS; w++) key_words[w] = '0;
    key_mask = '0;
    static_mask = '0;
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: a single-byte message first, with the key as it comes out of reset.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);
    wait_drained();
    load_key(KEY_ONES, 8'h00, 8'hFF);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    wait_drained();
    load_key(KEY_ZERO, 8'hFF, 8'h00);
    queue_message(3, 1'b1);
    wait_drained();

    // Open a message, let everything drain, then change the key mid-message.
    // The new key must only apply from the next message; the static mask at once.
    queue_message(3, 1'b0);
    wait_drained();
    load_key(KEY_RANDOM, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    queue_message(3, 1'b1);
    queue_message(1, 1'b1);
    wait_drained();
    load_key(KEY_RAMP, 8'h00, 8'h00);
    queue_message(4, 1'b1);
    wait_drained();

    // Random part: one register setting and one idle profile per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          load_key(KEY_RANDOM, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
          load_key(KEY_RANDOM, 8'h00, 8'hFF);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
          load_key(KEY_RANDOM, 8'hFF, 8'h00);
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
          load_key(KEY_RANDOM, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end
      endcase
      // Two halves with a full drain between them; a message may stay open across it.
      for (int half = 0; half < 2; half++) begin
        remaining = PHASE_ITEMS / 2;
        while (remaining > 0) begin
          len = message_length();
          if (len > remaining) len = remaining;
          remaining -= len;
          queue_message(len, (remaining > 0) || ($urandom_range(1) == 1));
        end
        wait_drained();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (plain_queue.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", plain_queue.size()));
    end
    $display("Decrypted %0d bytes over %0d key schedules; %0d results checked, %0d failures.",
             bytes_sent, schedules, bytes_checked, fail_count);
    $display("Used %0d register writes and four sender/receiver idle profiles.", reg_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
